@@ design/gpiolk_pkg.sv @@
`timescale 1ns / 1ps
package gpiolk_pkg;

    localparam int unsigned PIN_COUNT  = 16;
    localparam int unsigned CFG_W      = 32;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned HALF_PINS  = PIN_COUNT / 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 32'h4444_4444;
    localparam logic [3:0]       NIBBLE    = 4'hF;
    localparam int unsigned      LCKK_POS  = 16;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [2:0] SEL_CRL    = 3'd0;
    localparam logic [2:0] SEL_CRH    = 3'd1;
    localparam logic [2:0] SEL_IDR    = 3'd2;
    localparam logic [2:0] SEL_ODR    = 3'd3;
    localparam logic [2:0] SEL_BSRR   = 3'd4;
    localparam logic [2:0] SEL_BRR    = 3'd5;
    localparam logic [2:0] SEL_LCKR   = 3'd6;
    // No register behind this selector: reads give zero, writes are dropped.
    localparam logic [2:0] SEL_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        KEY_IDLE  = 2'd0,
        KEY_ONE   = 2'd1,
        KEY_TWO   = 2'd2,
        KEY_ARMED = 2'd3
    } key_step_t;

    // Lock state handed from the key sequencer to the register file.
    typedef struct packed {
        logic [PIN_COUNT-1:0] lock_bits;
        logic                 key_active;
        logic                 key_active_next;
    } lock_status_t;

    // Config bits frozen for eight pins while the key is active.
    function automatic logic [CFG_W-1:0] frozen_mask(
        input logic [HALF_PINS-1:0] lk,
        input logic                 act
    );
        logic [CFG_W-1:0] m;
        m = '0;
        for (int i = 0; i < HALF_PINS; i++) begin
            if (act && lk[i]) begin
                m[4*i +: 4] = NIBBLE;
            end
        end
        return m;
    endfunction

endpackage

@@ design/gpiolk_lock.sv @@
`timescale 1ns / 1ps
module gpiolk_lock
    import gpiolk_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              lock_acc,
    input  logic              lock_wr,
    input  logic [DATA_W-1:0] wdata,
    output lock_status_t      status
);

    key_step_t            step_reg, step_next;
    logic [PIN_COUNT-1:0] lock_bits_reg, lock_bits_next;
    logic                 active_reg, active_next;
    logic [PIN_COUNT-1:0] key_value_reg;
    logic                 key_load;

    logic [PIN_COUNT-1:0] val;
    logic                 lckk;
    logic                 same;

    assign val  = wdata[PIN_COUNT-1:0];
    assign lckk = wdata[LCKK_POS];
    assign same = (val == key_value_reg);

    // Next sequence step.
    always_comb begin
        step_next = step_reg;
        if (lock_acc && !active_reg) begin
            if (lock_wr) begin
                priority if (step_reg == KEY_ONE && !lckk && same) begin
                    step_next = KEY_TWO;
                end else if (step_reg == KEY_TWO && lckk && same) begin
                    step_next = KEY_ARMED;
                end else if (lckk) begin
                    step_next = KEY_ONE;
                end else begin
                    step_next = KEY_IDLE;
                end
            end else begin
                step_next = KEY_IDLE;
            end
        end
    end

    // Load enables and next values of the lock state.
    always_comb begin
        lock_bits_next = lock_bits_reg;
        active_next    = active_reg;
        key_load       = 1'b0;
        if (lock_acc && !active_reg) begin
            if (lock_wr) begin
                lock_bits_next = val;
                key_load = lckk && (step_next == KEY_ONE);
            end else if (step_reg == KEY_ARMED) begin
                active_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= KEY_IDLE;
            lock_bits_reg <= '0;
            active_reg    <= 1'b0;
        end else begin
            step_reg      <= step_next;
            lock_bits_reg <= lock_bits_next;
            active_reg    <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_load) begin
            key_value_reg <= val;
        end
    end

    assign status.lock_bits       = lock_bits_reg;
    assign status.key_active      = active_reg;
    assign status.key_active_next = active_next;

endmodule

@@ design/gpio_port_registers_with_lock.sv @@
`timescale 1ns / 1ps
// Sixteen-pin GPIO port register block, one register access per beat.
// Input channel (s_*): command (0 read, 1 write), reg_select (CRL, CRH,
// input data, output latch, set/reset, reset, lock), write_data and the
// sampled pin_levels. Result channel (m_*): read_data (zero on writes),
// the output latch after the access and the lock-active flag.
// The result of an access appears in the cycle after its input beat is
// taken, held in the result register. One access per cycle unless stalled;
// the only loop is the register state itself, updated in the accept cycle.
// The input side takes a new beat whenever the result register is empty or
// is being drained in the same cycle, so a stalled receiver holds the
// result and stops the input only until that result is taken.
// Reset (aresetn low, synchronous): CRL and CRH return to 0x44444444, the
// output latch and lock bits clear, the key sequence goes idle and the lock
// drops; the result register empties. The key compare value is not reset;
// it is loaded at the first step of every key sequence.
module gpio_port_registers_with_lock
    import gpiolk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [2:0]           s_reg_select,
    input  logic [DATA_W-1:0]    s_write_data,
    input  logic [PIN_COUNT-1:0] s_pin_levels,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_read_data,
    output logic [PIN_COUNT-1:0] m_output_latch,
    output logic                 m_lock_active
);

    logic [CFG_W-1:0]     crl_reg, crl_next;
    logic [CFG_W-1:0]     crh_reg, crh_next;
    logic [PIN_COUNT-1:0] odr_reg, odr_next;

    logic                 m_valid_reg;
    logic [DATA_W-1:0]    rd_reg;
    logic [PIN_COUNT-1:0] latch_reg;
    logic                 active_out_reg;

    logic [DATA_W-1:0]    rd_next;
    logic                 accept;
    logic                 is_wr;
    logic                 lock_acc;
    logic [CFG_W-1:0]     mask_lo;
    logic [CFG_W-1:0]     mask_hi;
    lock_status_t         lk;

    // Take a beat when the result slot is free or draining this cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_wr    = (s_command == CMD_WRITE);
    assign lock_acc = accept && (s_reg_select == SEL_LCKR);

    gpiolk_lock u_lock (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lock_acc (lock_acc),
        .lock_wr  (is_wr),
        .wdata    (s_write_data),
        .status   (lk)
    );

    // Locked pins keep their config nibble only while the key is active.
    assign mask_lo = frozen_mask(lk.lock_bits[HALF_PINS-1:0], lk.key_active);
    assign mask_hi = frozen_mask(lk.lock_bits[PIN_COUNT-1:HALF_PINS], lk.key_active);

    // Register writes.
    always_comb begin
        crl_next = crl_reg;
        crh_next = crh_reg;
        odr_next = odr_reg;
        if (accept && is_wr) begin
            unique case (s_reg_select)
                SEL_CRL:  crl_next = (crl_reg & mask_lo) | (s_write_data & ~mask_lo);
                SEL_CRH:  crh_next = (crh_reg & mask_hi) | (s_write_data & ~mask_hi);
                SEL_ODR:  odr_next = s_write_data[PIN_COUNT-1:0];
                // Set wins over clear where both bits of a pin are high.
                SEL_BSRR: odr_next = (odr_reg & ~s_write_data[DATA_W-1:PIN_COUNT])
                                     | s_write_data[PIN_COUNT-1:0];
                SEL_BRR:  odr_next = odr_reg & ~s_write_data[PIN_COUNT-1:0];
                default:  ;
            endcase
        end
    end

    // Read mux; lock read shows the state from before the access.
    always_comb begin
        rd_next = '0;
        if (!is_wr) begin
            unique case (s_reg_select)
                SEL_CRL:  rd_next = crl_reg;
                SEL_CRH:  rd_next = crh_reg;
                SEL_IDR:  rd_next = {{(DATA_W-PIN_COUNT){1'b0}}, s_pin_levels};
                SEL_ODR:  rd_next = {{(DATA_W-PIN_COUNT){1'b0}}, odr_reg};
                SEL_LCKR: rd_next = {{(DATA_W-PIN_COUNT-1){1'b0}}, lk.key_active,
                                     lk.lock_bits};
                default:  rd_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crl_reg     <= CFG_RESET;
            crh_reg     <= CFG_RESET;
            odr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            crl_reg <= crl_next;
            crh_reg <= crh_next;
            odr_reg <= odr_next;
            // Advance on a new beat, drop once the receiver takes it.
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold while stalled, load on every accepted beat.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg         <= rd_next;
            latch_reg      <= odr_next;
            active_out_reg <= lk.key_active_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_read_data    = rd_reg;
    assign m_output_latch = latch_reg;
    assign m_lock_active  = active_out_reg;

endmodule
